// ===== rtl/core/fsktm_pkg.sv =====
// fsktm_pkg: shared types, constants and sine tables for the FSK tape modulator.
// No dependencies; used by fsk_tape_byte_modulator_unit and fsktm_sine.
`default_nettype none

package fsktm_pkg;

  localparam int SINE_ENTRIES    = 256;
  localparam int PHASE_FRAC_BITS = 24;
  localparam int IDX_BITS        = $clog2(SINE_ENTRIES);

  localparam int STEP_BITS     = 22;
  localparam int CPB_BITS      = 8;
  localparam int STOP_BITS_W   = 4;
  localparam int CELL_BITS     = 5;
  localparam int SAMPLE_BITS   = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 22;

  localparam logic [CELL_BITS-1:0]   DATA_CELLS  = 5'd8;
  localparam logic [SAMPLE_BITS-1:0] CENTER      = 16'd128;
  localparam longint unsigned        NARROW_AMP  = 127;
  localparam longint unsigned        WIDE_AMP    = 32767;

  localparam logic [STEP_BITS-1:0]   RST_STEP    = 22'd1826091;
  localparam logic [CPB_BITS-1:0]    RST_CPB     = 8'd2;
  localparam logic [STOP_BITS_W-1:0] RST_STOP    = 4'd3;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

  typedef enum logic [1:0] {
    OP_SILENCE = 2'd0,
    OP_MARK    = 2'd1,
    OP_FRAME   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PHASE_STEP     = 2'd0,
    REG_CYCLES_PER_BIT = 2'd1,
    REG_STOP_BITS      = 2'd2,
    REG_WIDE_SAMPLES   = 2'd3
  } cfg_reg_t;

  typedef logic [SAMPLE_BITS-1:0] sine_tab_t [SINE_ENTRIES];

  // round(32767*sin(num/SINE_ENTRIES * pi/2)), Q30 Taylor through x^9
  function automatic longint unsigned quarter_sine(longint unsigned num);
    longint unsigned x;
    longint unsigned th;
    longint unsigned th2;
    longint unsigned f;
    longint unsigned s;
    longint unsigned v;
    x   = (num << 30) / SINE_ENTRIES;
    th  = (x * Q30_HALF_PI) >> 30;
    th2 = (th * th) >> 30;
    f   = Q30_ONE - th2 / 72;
    f   = Q30_ONE - ((th2 * f) >> 30) / 42;
    f   = Q30_ONE - ((th2 * f) >> 30) / 20;
    f   = Q30_ONE - ((th2 * f) >> 30) / 6;
    s   = (th * f) >> 30;
    v   = (s * WIDE_AMP + (Q30_ONE >> 1)) >> 30;
    if (v > WIDE_AMP) v = WIDE_AMP;
    return v;
  endfunction

  // magnitude of the sine at table entry k; the sine is negative in the second half
  function automatic longint unsigned sine_mag(int k);
    longint unsigned t;
    longint unsigned q;
    longint unsigned r;
    longint unsigned n;
    n = SINE_ENTRIES;
    t = longint'(k) * 4;
    q = t / SINE_ENTRIES;
    r = t % SINE_ENTRIES;
    if (q == 0 || q == 2) return quarter_sine(r);
    return quarter_sine(n - r);
  endfunction

  function automatic sine_tab_t build_wide_tab();
    sine_tab_t tab;
    longint unsigned m;
    bit neg;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      m   = sine_mag(k);
      neg = (k >= SINE_ENTRIES / 2);
      // sample is the negated sine
      tab[k] = neg ? m[SAMPLE_BITS-1:0] : SAMPLE_BITS'(16'd0 - m[SAMPLE_BITS-1:0]);
    end
    return tab;
  endfunction

  function automatic sine_tab_t build_narrow_tab();
    sine_tab_t tab;
    longint unsigned m;
    longint unsigned d;
    bit neg;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      m   = sine_mag(k);
      neg = (k >= SINE_ENTRIES / 2);
      d = (m * NARROW_AMP + 16383) / WIDE_AMP;
      tab[k] = neg ? SAMPLE_BITS'(CENTER + d[SAMPLE_BITS-1:0])
                   : SAMPLE_BITS'(CENTER - d[SAMPLE_BITS-1:0]);
    end
    return tab;
  endfunction

  localparam sine_tab_t WIDE_TAB   = build_wide_tab();
  localparam sine_tab_t NARROW_TAB = build_narrow_tab();

endpackage

`default_nettype wire

// ===== rtl/core/fsktm_in_if.sv =====
// fsktm_in_if: valid/ready channel carrying one sample tick request.
// Depends on nothing.
`default_nettype none

interface fsktm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic       data_valid;

  modport source (output valid, output op, output data_byte, output data_valid,
                  input ready);
  modport sink   (input valid, input op, input data_byte, input data_valid,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fsktm_out_if.sv =====
// fsktm_out_if: valid/ready channel carrying one audio sample and frame flags.
// Depends on nothing.
`default_nettype none

interface fsktm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               byte_taken;
  logic               cell_end;
  logic               frame_end;

  modport source (output valid, output sample, output byte_taken, output cell_end,
                  output frame_end, input ready);
  modport sink   (input valid, input sample, input byte_taken, input cell_end,
                  input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fsk_tape_byte_modulator_unit.sv =====
// fsk_tape_byte_modulator_unit: cassette FSK modulator top level.
// Depends on fsktm_pkg, fsktm_in_if, fsktm_out_if and fsktm_sine.
//
// Usage:
//   tick  - one item per audio sample: op (silence, mark tone, frame sample),
//           data_byte and data_valid. A frame starts on a frame op with
//           data_valid set while no frame runs; the byte is ignored otherwise.
//   audio - one item per tick: sample (8-bit offset or 16-bit signed format),
//           byte_taken, cell_end and frame_end.
//   cfg_* - register writes (phase step, periods per bit, stop cells, sample
//           format), taken with cfg_we high; write only while the block is idle, not enforced by the block.
// A tick passes one input register, then the phase/cell update and table lookup
// into the result register, before the result shows on audio. Throughput is
// one item per cycle while audio does not stall; the phase accumulator and
// cell counters update combinationally from their registered values.
// Reset clears phase, frame state and both pipeline registers and loads the
// register defaults. When audio stalls, the result register holds and the
// input register still takes one more item; tick.ready then drops until the
// result moves.
`default_nettype none

module fsk_tape_byte_modulator_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  fsktm_in_if.sink                              tick,
  fsktm_out_if.source                           audio,
  input  logic                                  cfg_we,
  input  logic [fsktm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fsktm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int PFB = fsktm_pkg::PHASE_FRAC_BITS;
  localparam int CB  = fsktm_pkg::CELL_BITS;
  localparam int PB  = fsktm_pkg::CPB_BITS;

  // configuration
  logic [fsktm_pkg::STEP_BITS-1:0]   phase_step;
  logic [PB-1:0]                     cycles_per_bit;
  logic [fsktm_pkg::STOP_BITS_W-1:0] stop_bits;
  logic                              wide_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step     <= fsktm_pkg::RST_STEP;
      cycles_per_bit <= fsktm_pkg::RST_CPB;
      stop_bits      <= fsktm_pkg::RST_STOP;
      wide_samples   <= 1'b0;
    end else if (cfg_we) begin
      unique case (fsktm_pkg::cfg_reg_t'(cfg_index))
        fsktm_pkg::REG_PHASE_STEP:     phase_step     <= cfg_data[fsktm_pkg::STEP_BITS-1:0];
        fsktm_pkg::REG_CYCLES_PER_BIT: cycles_per_bit <= cfg_data[PB-1:0];
        fsktm_pkg::REG_STOP_BITS:      stop_bits      <= cfg_data[fsktm_pkg::STOP_BITS_W-1:0];
        fsktm_pkg::REG_WIDE_SAMPLES:   wide_samples   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [7:0] s1_byte;
  logic       s1_dvalid;
  logic       advance;
  logic       out_valid;

  assign advance    = !out_valid || audio.ready;
  assign tick.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      s1_op     <= tick.op;
      s1_byte   <= tick.data_byte;
      s1_dvalid <= tick.data_valid;
    end
  end

  // modulator state
  logic [PFB-1:0] phase_fraction, phase_fraction_next;
  logic [PB-1:0]  periods_in_cell, periods_in_cell_next;
  logic [CB-1:0]  cell_index, cell_index_next;
  logic [7:0]     shift_byte, shift_byte_next;
  logic           frame_active, frame_active_next;

  logic           silence;
  logic           high;
  logic           taken, cend, fend;
  logic [PFB:0]   sum;
  logic [PB-1:0]  limit;
  logic [PB-1:0]  pic_inc;
  logic [CB-1:0]  last_cell;
  logic [15:0]    tone;

  fsktm_sine u_sine (
    .phase  (phase_fraction),
    .high   (high),
    .wide   (wide_samples),
    .sample (tone)
  );

  always_comb begin
    phase_fraction_next  = phase_fraction;
    periods_in_cell_next = periods_in_cell;
    cell_index_next      = cell_index;
    shift_byte_next      = shift_byte;
    frame_active_next    = frame_active;
    silence = 1'b0;
    taken   = 1'b0;
    cend    = 1'b0;
    fend    = 1'b0;
    high    = 1'b1;
    sum       = {1'b0, phase_fraction} + (PFB+1)'(phase_step);
    limit     = (cycles_per_bit == '0) ? PB'(1) : cycles_per_bit;
    last_cell = fsktm_pkg::DATA_CELLS + CB'(stop_bits);
    pic_inc   = '0;
    case (fsktm_pkg::op_t'(s1_op))
      fsktm_pkg::OP_MARK: begin
        frame_active_next    = 1'b0;
        periods_in_cell_next = '0;
        cell_index_next      = '0;
      end
      fsktm_pkg::OP_FRAME: begin
        if (!frame_active && s1_dvalid) begin
          shift_byte_next      = s1_byte;
          frame_active_next    = 1'b1;
          cell_index_next      = '0;
          periods_in_cell_next = '0;
          taken                = 1'b1;
        end
      end
      default: begin
        silence              = 1'b1;
        frame_active_next    = 1'b0;
        periods_in_cell_next = '0;
        cell_index_next      = '0;
      end
    endcase
    if (!silence) begin
      if (frame_active_next) begin
        if (cell_index_next == '0) begin
          high = 1'b0;
        end else if (cell_index_next <= fsktm_pkg::DATA_CELLS) begin
          high = shift_byte_next[0];
        end
      end
      phase_fraction_next = sum[PFB-1:0];
      if (frame_active_next && sum[PFB]) begin
        pic_inc              = periods_in_cell_next + PB'(1);
        periods_in_cell_next = pic_inc;
        if (pic_inc >= limit) begin
          cend                 = 1'b1;
          periods_in_cell_next = '0;
          if (cell_index_next >= CB'(1) && cell_index_next <= fsktm_pkg::DATA_CELLS) begin
            shift_byte_next = {1'b0, shift_byte_next[7:1]};
          end
          if (cell_index_next >= last_cell) begin
            fend              = 1'b1;
            frame_active_next = 1'b0;
            cell_index_next   = '0;
          end else begin
            cell_index_next = cell_index_next + CB'(1);
          end
        end
      end
    end
  end

  logic fire;
  assign fire = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_fraction  <= '0;
      periods_in_cell <= '0;
      cell_index      <= '0;
      shift_byte      <= '0;
      frame_active    <= 1'b0;
    end else if (fire) begin
      phase_fraction  <= phase_fraction_next;
      periods_in_cell <= periods_in_cell_next;
      cell_index      <= cell_index_next;
      shift_byte      <= shift_byte_next;
      frame_active    <= frame_active_next;
    end
  end

  // result register
  logic [15:0] out_sample;
  logic        out_taken, out_cend, out_fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (silence) begin
        out_sample <= wide_samples ? 16'd0 : fsktm_pkg::CENTER;
      end else begin
        out_sample <= tone;
      end
      out_taken <= taken;
      out_cend  <= cend;
      out_fend  <= fend;
    end
  end

  assign audio.valid      = out_valid;
  assign audio.sample     = out_sample;
  assign audio.byte_taken = out_taken;
  assign audio.cell_end   = out_cend;
  assign audio.frame_end  = out_fend;

  // checks
  a_fend_has_cend: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_fend || out_cend))
    else $error("frame_end without cell_end");

  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    !frame_active |-> (periods_in_cell == '0 && cell_index == '0))
    else $error("cell counters live outside a frame");

  a_cell_bound: assert property (@(posedge clk) disable iff (rst)
    cell_index <= fsktm_pkg::DATA_CELLS + CB'(15))
    else $error("cell index out of range");

  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("result lost after advance");

  a_taken_starts: assert property (@(posedge clk) disable iff (rst)
    (fire && taken && !fend) |=> frame_active)
    else $error("byte taken but no frame running");

endmodule

`default_nettype wire

// ===== rtl/core/fsktm_sine.sv =====
// fsktm_sine: phase to sample lookup (mark doubling, table select by format).
// Depends on fsktm_pkg constant tables.
`default_nettype none

module fsktm_sine (
  input  logic [fsktm_pkg::PHASE_FRAC_BITS-1:0] phase,
  input  logic                                  high,
  input  logic                                  wide,
  output logic [fsktm_pkg::SAMPLE_BITS-1:0]     sample
);

  logic [fsktm_pkg::PHASE_FRAC_BITS-1:0] u;
  logic [fsktm_pkg::IDX_BITS-1:0]        idx;

  assign u   = high ? {phase[fsktm_pkg::PHASE_FRAC_BITS-2:0], 1'b0} : phase;
  assign idx = u[fsktm_pkg::PHASE_FRAC_BITS-1 -: fsktm_pkg::IDX_BITS];

  always_comb begin
    if (wide) begin
      sample = fsktm_pkg::WIDE_TAB[idx];
    end else begin
      sample = fsktm_pkg::NARROW_TAB[idx];
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for fsk_tape_byte_modulator_unit: random and directed sample ticks are
// checked against an in-bench model of the FSK modulator, over several register settings.
// Depends on fsktm_pkg, fsktm_in_if, fsktm_out_if and the RTL of the unit.
module testbench;
  import fsktm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 300;
  localparam int LONG_HOLD   = 120;
  localparam longint unsigned FIX_ONE     = 64'd1073741824;
  localparam longint unsigned FIX_HALF_PI = 64'd1686629713;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       data_valid;
  } tick_item_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        byte_taken;
    logic        cell_end;
    logic        frame_end;
  } audio_item_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  fsktm_in_if  tick_ch ();
  fsktm_out_if audio_ch ();

  fsk_tape_byte_modulator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .audio     (audio_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // model of the modulator
  int                     sine_q15 [SINE_ENTRIES];
  logic [STEP_BITS-1:0]   set_step;
  logic [CPB_BITS-1:0]    set_cpb;
  logic [STOP_BITS_W-1:0] set_stop;
  logic                   set_wide;
  logic [PHASE_FRAC_BITS-1:0] acc_phase;
  logic [7:0]             cell_periods;
  logic [CELL_BITS-1:0]   cell_num;
  logic [7:0]             shreg;
  logic                   in_frame;

  tick_item_t  tick_backlog [$];
  audio_item_t expected_audio [$];
  tick_item_t  offered;
  logic        tick_free;
  int          src_gap_max;
  int          snk_gap_max;
  int          src_wait;
  int          snk_wait;
  int          stall_draw;
  int          results_seen;
  int          ticks_queued;
  logic        mismatch_found;

  function automatic int quarter_wave(longint unsigned num);
    longint unsigned divs [4] = '{72, 42, 20, 6};
    longint unsigned ang;
    longint unsigned a2;
    longint unsigned poly;
    longint unsigned y;
    ang  = (((num << 30) / SINE_ENTRIES) * FIX_HALF_PI) >> 30;
    a2   = (ang * ang) >> 30;
    poly = FIX_ONE;
    foreach (divs[i]) poly = FIX_ONE - ((a2 * poly) >> 30) / divs[i];
    y = (((ang * poly) >> 30) * 32767 + (FIX_ONE >> 1)) >> 30;
    return (y > 32767) ? 32767 : int'(y);
  endfunction

  function automatic void fill_sine();
    longint unsigned quad;
    longint unsigned rem;
    int mag;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      quad = (longint'(k) * 4) / SINE_ENTRIES;
      rem  = (longint'(k) * 4) % SINE_ENTRIES;
      mag  = (quad == 0 || quad == 2) ? quarter_wave(rem) : quarter_wave(SINE_ENTRIES - rem);
      sine_q15[k] = (quad >= 2) ? -mag : mag;
    end
  endfunction

  function automatic logic [15:0] tone_sample(logic high);
    logic [PHASE_FRAC_BITS-1:0] ph;
    int v;
    int d;
    ph = high ? {acc_phase[PHASE_FRAC_BITS-2:0], 1'b0} : acc_phase;
    v  = sine_q15[ph[PHASE_FRAC_BITS-1 -: IDX_BITS]];
    if (set_wide) return 16'(-v);
    d = ((v < 0 ? -v : v) * 127 + 16383) / 32767;
    return (v < 0) ? 16'(128 + d) : 16'(128 - d);
  endfunction

  task automatic modulate_tick(tick_item_t it);
    audio_item_t res;
    logic high;
    logic [PHASE_FRAC_BITS:0] sum;
    logic [7:0] lim;
    res = '0;
    if (it.op == OP_SILENCE || it.op == OP_UNUSED) begin
      in_frame = 1'b0;
      cell_periods = '0;
      cell_num = '0;
      res.sample = set_wide ? 16'd0 : 16'd128;
      expected_audio.push_back(res);
      return;
    end
    if (it.op == OP_MARK) begin
      in_frame = 1'b0;
      cell_periods = '0;
      cell_num = '0;
    end else if (!in_frame && it.data_valid) begin
      shreg = it.data_byte;
      in_frame = 1'b1;
      cell_num = '0;
      cell_periods = '0;
      res.byte_taken = 1'b1;
    end
    high = 1'b1;
    if (in_frame) begin
      if (cell_num == 0) high = 1'b0;
      else if (cell_num <= 8) high = shreg[0];
    end
    res.sample = tone_sample(high);
    sum = {1'b0, acc_phase} + (PHASE_FRAC_BITS+1)'(set_step);
    acc_phase = sum[PHASE_FRAC_BITS-1:0];
    if (in_frame && sum[PHASE_FRAC_BITS]) begin
      lim = (set_cpb == 0) ? 8'd1 : set_cpb;
      cell_periods = cell_periods + 8'd1;
      if (cell_periods >= lim) begin
        res.cell_end = 1'b1;
        cell_periods = '0;
        if (cell_num >= 1 && cell_num <= 8) shreg = shreg >> 1;
        if (int'(cell_num) >= 8 + int'(set_stop)) begin
          res.frame_end = 1'b1;
          in_frame = 1'b0;
          cell_num = '0;
        end else begin
          cell_num = cell_num + 1'b1;
        end
      end
    end
    expected_audio.push_back(res);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
      src_wait <= 0;
    end else begin
      tick_free = !tick_ch.valid;
      if (tick_ch.valid && tick_ch.ready) begin
        modulate_tick(offered);
        tick_free = 1'b1;
      end
      if (tick_free) begin
        if (src_wait != 0) begin
          src_wait <= src_wait - 1;
          tick_ch.valid <= 1'b0;
        end else if (tick_backlog.size() != 0) begin
          offered = tick_backlog.pop_front();
          tick_ch.op <= offered.op;
          tick_ch.data_byte <= offered.data_byte;
          tick_ch.data_valid <= offered.data_valid;
          tick_ch.valid <= 1'b1;
          src_wait <= $urandom_range(0, src_gap_max);
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void flag_field(string name, logic signed [16:0] want,
                                     logic signed [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_found = 1'b1;
    end
  endfunction

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      audio_ch.ready <= 1'b0;
      snk_wait <= 0;
    end else begin
      if (audio_ch.valid && audio_ch.ready) begin
        if (expected_audio.size() == 0) begin
          $error("audio item with no expected result");
          mismatch_found = 1'b1;
        end else begin
          audio_item_t want;
          want = expected_audio.pop_front();
          flag_field("sample", $signed(want.sample), audio_ch.sample);
          flag_field("byte_taken", want.byte_taken, audio_ch.byte_taken);
          flag_field("cell_end", want.cell_end, audio_ch.cell_end);
          flag_field("frame_end", want.frame_end, audio_ch.frame_end);
        end
        results_seen = results_seen + 1;
        stall_draw = (results_seen == HOLD_AT) ? LONG_HOLD : $urandom_range(0, snk_gap_max);
        if (stall_draw != 0) begin
          audio_ch.ready <= 1'b0;
          snk_wait <= stall_draw - 1;
        end
      end else if (snk_wait != 0) begin
        snk_wait <= snk_wait - 1;
      end else begin
        audio_ch.ready <= 1'b1;
      end
    end
  end

  task automatic add_tick(op_t op, logic [7:0] b, logic dv);
    tick_item_t it;
    it.op = op;
    it.data_byte = b;
    it.data_valid = dv;
    tick_backlog.push_back(it);
    ticks_queued++;
  endtask

  // estimate of the ticks of one frame at the current setting, capped at 300 (40 for a zero step)
  function automatic int frame_span();
    longint unsigned periods;
    longint unsigned n;
    if (set_step == 0) return 40;
    periods = (9 + set_stop) * ((set_cpb == 0) ? 1 : set_cpb);
    n = (periods << PHASE_FRAC_BITS) / set_step + 2;
    return (n > 300) ? 300 : int'(n);
  endfunction

  task automatic random_traffic(int target);
    int start;
    int kind;
    int span;
    int lead;
    int room;
    start = ticks_queued;
    while (ticks_queued - start < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        lead = $urandom_range(0, 4);
        for (int i = 0; i < lead; i++)
          add_tick($urandom_range(0, 1) ? OP_MARK : OP_FRAME, 8'($urandom), 1'b0);
        span = frame_span();
        if (kind == 6) span = $urandom_range(1, span);
        else span = span + $urandom_range(0, 3);
        room = target - (ticks_queued - start);
        if (span > room) span = (room < 1) ? 1 : room;
        add_tick(OP_FRAME, 8'($urandom), 1'b1);
        for (int i = 1; i < span; i++)
          add_tick(OP_FRAME, 8'($urandom), $urandom_range(0, 3) == 0);
        if (kind == 6)
          add_tick(op_t'($urandom_range(0, 1) ? OP_MARK : op_t'($urandom_range(0, 1) * 3)),
                   8'($urandom), 1'($urandom_range(0, 1)));
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 5))
          add_tick(op_t'($urandom_range(0, 1) * 3), 8'($urandom), 1'($urandom_range(0, 1)));
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 8))
          add_tick(OP_MARK, 8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 10))
          add_tick(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic settle();
    while (tick_backlog.size() != 0 || tick_ch.valid || expected_audio.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic reconfigure(logic [STEP_BITS-1:0] step, logic [CPB_BITS-1:0] cpb,
                             logic [STOP_BITS_W-1:0] stop, logic wide,
                             int src_max, int snk_max);
    settle();
    write_reg(REG_PHASE_STEP, CFG_DATA_BITS'(step));
    write_reg(REG_CYCLES_PER_BIT, CFG_DATA_BITS'(cpb));
    write_reg(REG_STOP_BITS, CFG_DATA_BITS'(stop));
    write_reg(REG_WIDE_SAMPLES, CFG_DATA_BITS'(wide));
    cfg_we <= 1'b0;
    set_step = step;
    set_cpb = cpb;
    set_stop = stop;
    set_wide = wide;
    src_gap_max = src_max;
    snk_gap_max = snk_max;
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.op = OP_SILENCE;
    tick_ch.data_byte = '0;
    tick_ch.data_valid = 1'b0;
    audio_ch.ready = 1'b0;
    fill_sine();
    set_step = RST_STEP;
    set_cpb = RST_CPB;
    set_stop = RST_STOP;
    set_wide = 1'b0;
    acc_phase = '0;
    cell_periods = '0;
    cell_num = '0;
    shreg = '0;
    in_frame = 1'b0;
    src_gap_max = 3;
    snk_gap_max = 3;
    results_seen = 0;
    ticks_queued = 0;
    mismatch_found = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed ticks at reset settings
    add_tick(OP_SILENCE, 8'hFF, 1'b1);
    add_tick(OP_UNUSED, 8'h00, 1'b0);
    add_tick(OP_MARK, 8'h00, 1'b1);
    add_tick(OP_MARK, 8'hFF, 1'b0);
    add_tick(OP_FRAME, 8'h3C, 1'b0);
    add_tick(OP_FRAME, 8'hA5, 1'b1);
    add_tick(OP_FRAME, 8'h5A, 1'b1);
    add_tick(OP_FRAME, 8'h00, 1'b0);
    add_tick(OP_MARK, 8'h11, 1'b1);
    add_tick(OP_FRAME, 8'hFF, 1'b1);
    repeat (4) add_tick(OP_FRAME, 8'h00, 1'b1);
    add_tick(OP_SILENCE, 8'h00, 1'b0);
    add_tick(OP_FRAME, 8'h00, 1'b1);
    repeat (4) add_tick(OP_FRAME, 8'hFF, 1'b0);
    add_tick(OP_UNUSED, 8'hFF, 1'b1);
    add_tick(OP_FRAME, 8'h80, 1'b0);
    add_tick(OP_FRAME, 8'h01, 1'b1);
    random_traffic(100);

    reconfigure(22'h3FFFFF, 8'd1, 4'd0, 1'b1, 0, 0);
    random_traffic(80);
    reconfigure(22'h3FFFFF, 8'd0, 4'd15, 1'b0, 3, 3);
    random_traffic(80);
    reconfigure(22'd2097152, 8'd3, 4'd2, 1'b1, 3, 0);
    random_traffic(80);
    repeat (2) begin
      reconfigure(STEP_BITS'($urandom_range(1048576, 4194303)),
                  CPB_BITS'($urandom_range(1, 3)),
                  STOP_BITS_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 0, 3);
      random_traffic(80);
    end
    reconfigure(22'd1, 8'd1, 4'd1, 1'b0, 3, 3);
    random_traffic(30);
    reconfigure(22'd0, 8'd5, 4'd0, 1'b1, 3, 3);
    random_traffic(30);

    // long bit cell: one frame run long enough to close its start cell
    reconfigure(22'h3FFFFF, 8'd40, 4'd15, 1'b1, 1, 1);
    add_tick(OP_FRAME, 8'($urandom), 1'b1);
    repeat (170) add_tick(OP_FRAME, 8'($urandom), 1'($urandom_range(0, 1)));

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_found)
      $display("TEST FAILED");
    else
      $display("TEST PASSED");
    $finish;
  end

endmodule
